### hw/rtl/assert_macros.svh
// Assertion macros used by the pixel format converter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies expr in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Check that cond implies expr in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

### hw/rtl/pfc_pkg.sv
// Shared types and constants of the pixel format converter.
package pfc_pkg;

   localparam int MEM_PIXEL_W   = 16;
   localparam int EXT_BYTES_W   = 32;
   localparam int BYTE_COUNT_W  = 3;
   localparam int CSR_INDEX_W   = 8;
   localparam int CSR_DATA_W    = 16;
   localparam int REQ_TDATA_W   = 48;
   localparam int RSP_TDATA_W   = 56;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MEM_FORMAT     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXT_FORMAT     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXT_BIG_ENDIAN = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSP_CODE    = 8'd3;

   // Memory formats
   localparam logic MEM_RGB565   = 1'b0;
   localparam logic MEM_ARGB1555 = 1'b1;

   // External formats
   localparam logic [1:0] EXT_RGB24  = 2'd0;
   localparam logic [1:0] EXT_RGB32  = 2'd1;
   localparam logic [1:0] EXT_RGBA32 = 2'd2;

   // Operations
   localparam logic OP_EXPAND = 1'b0;
   localparam logic OP_PACK   = 1'b1;

   localparam logic [MEM_PIXEL_W-1:0]  TRANSP_CODE_RST = 16'd14798;
   localparam logic [BYTE_COUNT_W-1:0] COUNT_THREE     = 3'd3;
   localparam logic [BYTE_COUNT_W-1:0] COUNT_FOUR      = 3'd4;

   typedef struct packed {
      logic                   mem_format;
      logic [1:0]             ext_format;
      logic                   ext_big_endian;
      logic [MEM_PIXEL_W-1:0] transparent_code;
   } cfg_type;

   typedef struct packed {
      logic                   op;
      logic [MEM_PIXEL_W-1:0] mem_pixel;
      logic [EXT_BYTES_W-1:0] ext_bytes;
   } req_item_type;

   typedef struct packed {
      logic [MEM_PIXEL_W-1:0]  mem_pixel_out;
      logic [EXT_BYTES_W-1:0]  ext_bytes_out;
      logic [BYTE_COUNT_W-1:0] byte_count;
   } rsp_item_type;

endpackage

### hw/rtl/pixel_format_converter_unit.sv
// Top level of the pixel format converter: stream ports, pipeline registers, checks.
// Converts one pixel per word between a 16-bit memory word (RGB565 or ARGB1555)
// and 3 or 4 external bytes (RGB24, RGB32, RGBA32, in B,G,R,A or A,R,G,B order).
// Every request word gives exactly one response word. The pipeline has two
// register stages, an input register and a result register, with only the
// combinational logic of pfc_core between them, so a word can enter every
// cycle while the response side is not stalled and leaves from the result register.
// The result register lets a new word be taken while a finished one waits.
// Configuration is written through the csr_ port at any time and is always
// ready; change it only while no words are in flight.
`include "assert_macros.svh"
module pixel_format_converter_unit
   import pfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // mem_pixel[15:0], ext_bytes[47:16]
   input  logic [0:0]             req_tuser,  // op[0]
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // mem_pixel_out[15:0], ext_bytes_out[47:16],
                                              // byte_count[50:48], zero[55:51]
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type      cfg;
   req_item_type req_ff;
   req_item_type req_in;
   logic         req_vld_ff;
   logic         req_vld_in;
   rsp_item_type rsp_ff;
   rsp_item_type rsp_in;
   logic         rsp_vld_ff;
   logic         rsp_vld_in;
   rsp_item_type conv;
   logic         rsp_free;
   logic         advance;
   logic         take;

   pfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pfc_core u_core (
      .cfg    (cfg),
      .item   (req_ff),
      .result (conv)
   );

   // The result register can take a word when empty or draining this cycle.
   assign rsp_free   = !rsp_vld_ff || rsp_tready;
   // Advance the input register into the result register.
   assign advance    = req_vld_ff && rsp_free;
   // Take a new request when the input register is empty or moving on.
   assign req_tready = !req_vld_ff || rsp_free;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      req_in     = req_ff;
      req_vld_in = req_vld_ff;
      if (take) begin
         req_in.op        = req_tuser[0];
         req_in.mem_pixel = req_tdata[MEM_PIXEL_W-1:0];
         req_in.ext_bytes = req_tdata[MEM_PIXEL_W+EXT_BYTES_W-1:MEM_PIXEL_W];
         req_vld_in       = 1'b1;
      end else if (advance) begin
         req_vld_in = 1'b0;   // drop the word once it has moved on
      end
   end

   always_comb begin
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_in     = conv;
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'b00000, rsp_ff.byte_count, rsp_ff.ext_bytes_out,
                        rsp_ff.mem_pixel_out};

   `ASSERT_NEXT(a_hold_stalled_input, clock, reset, req_vld_ff && !rsp_free,
      req_vld_ff && $stable(req_ff), "held request word changed or was lost")
   `ASSERT_IMPLY(a_no_take_when_full, clock, reset, req_vld_ff && !rsp_free,
      !req_tready, "request taken while both stages are full")
   `ASSERT_IMPLY(a_one_field_used, clock, reset, rsp_vld_ff,
      rsp_ff.mem_pixel_out == '0 || rsp_ff.ext_bytes_out == '0,
      "both result fields in use")
   `ASSERT_IMPLY(a_byte_count_legal, clock, reset, rsp_vld_ff,
      rsp_ff.byte_count == COUNT_THREE || rsp_ff.byte_count == COUNT_FOUR,
      "byte count out of range")

endmodule

### hw/rtl/pfc_csr.sv
// Configuration registers of the pixel format converter.
module pfc_csr
   import pfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_index)
            CSR_MEM_FORMAT:     cfg_in.mem_format       = csr_data[0];
            CSR_EXT_FORMAT:     cfg_in.ext_format       = csr_data[1:0];
            CSR_EXT_BIG_ENDIAN: cfg_in.ext_big_endian   = csr_data[0];
            CSR_TRANSP_CODE:    cfg_in.transparent_code = csr_data[MEM_PIXEL_W-1:0];
            default:            cfg_in = cfg_ff;   // ignore indexes past the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mem_format       <= MEM_RGB565;
         cfg_ff.ext_format       <= EXT_RGB32;
         cfg_ff.ext_big_endian   <= 1'b0;
         cfg_ff.transparent_code <= TRANSP_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/pfc_core.sv
// Combinational pack and expand datapath of the pixel format converter.
module pfc_core
   import pfc_pkg::*;
(
   input  cfg_type      cfg,
   input  req_item_type item,
   output rsp_item_type result
);

   logic       three;
   logic       alpha_on;
   logic [7:0] p_r, p_g, p_b, p_a;
   logic [7:0] x_r, x_g, x_b, x_a;
   logic [MEM_PIXEL_W-1:0] packed_word;
   logic [EXT_BYTES_W-1:0] expanded;

   function automatic logic [7:0] widen5(input logic [4:0] v);
      widen5 = {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      widen6 = {v, v[5:4]};
   endfunction

   assign three    = (cfg.ext_format == EXT_RGB24);
   assign alpha_on = (cfg.ext_format == EXT_RGBA32);

   // Pick channels out of the stream bytes.
   always_comb begin
      if (cfg.ext_big_endian) begin
         if (three) begin
            p_a = 8'hff;
            p_r = item.ext_bytes[7:0];
            p_g = item.ext_bytes[15:8];
            p_b = item.ext_bytes[23:16];
         end else begin
            p_a = item.ext_bytes[7:0];
            p_r = item.ext_bytes[15:8];
            p_g = item.ext_bytes[23:16];
            p_b = item.ext_bytes[31:24];
         end
      end else begin
         p_b = item.ext_bytes[7:0];
         p_g = item.ext_bytes[15:8];
         p_r = item.ext_bytes[23:16];
         p_a = three ? 8'hff : item.ext_bytes[31:24];
      end
   end

   always_comb begin
      if (cfg.mem_format == MEM_ARGB1555) begin
         if (alpha_on && (p_a == 8'h00)) begin
            packed_word = cfg.transparent_code;
         end else begin
            packed_word = {1'b1, p_r[7:3], p_g[7:3], p_b[7:3]};
         end
      end else begin
         packed_word = {p_r[7:3], p_g[7:2], p_b[7:3]};
      end
   end

   // Widen channels by repeating their top bits and order them into the stream bytes.
   always_comb begin
      x_b = widen5(item.mem_pixel[4:0]);
      if (cfg.mem_format == MEM_ARGB1555) begin
         x_g = widen5(item.mem_pixel[9:5]);
         x_r = widen5(item.mem_pixel[14:10]);
         x_a = item.mem_pixel[15] ? 8'hff : 8'h00;
      end else begin
         x_g = widen6(item.mem_pixel[10:5]);
         x_r = widen5(item.mem_pixel[15:11]);
         x_a = 8'hff;
      end
      if (cfg.ext_big_endian) begin
         expanded = three ? {8'h00, x_b, x_g, x_r} : {x_b, x_g, x_r, x_a};
      end else begin
         expanded = {(three ? 8'h00 : x_a), x_r, x_g, x_b};
      end
   end

   always_comb begin
      result.byte_count = three ? COUNT_THREE : COUNT_FOUR;
      if (item.op == OP_PACK) begin
         result.mem_pixel_out = packed_word;
         result.ext_bytes_out = '0;
      end else begin
         result.mem_pixel_out = '0;
         result.ext_bytes_out = expanded;
      end
   end

endmodule
